// ===== rtl/m4i_pkg.sv =====
// m4i_pkg: shared types, register indexes and fixed-point helpers for the
// 4x4 Gauss-Jordan inverse block. No dependencies.
`default_nettype none

package m4i_pkg;

  localparam int DATA_W  = 32;
  localparam int EPS_W   = 17;
  localparam int CFG_IDX_W = 8;
  localparam int INDEX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIVOT_EPS  = 8'd0,
    CFG_FACTOR_EPS = 8'd1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_INIT,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_PIV_TEST,
    ST_SWP_RDA,
    ST_SWP_RDB,
    ST_SWP_WRA,
    ST_SWP_WRB,
    ST_PIV_RD,
    ST_PIV_LAT,
    ST_DIV_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FAC_RD,
    ST_FAC_CHK,
    ST_MUL_RDP,
    ST_MUL_PROD,
    ST_MUL_TRN,
    ST_MUL_SUB,
    ST_ROW_NEXT,
    ST_OUT_RD,
    ST_OUT_PUT,
    ST_OUT_SING
  } eng_state_t;

  // exact magnitude of a signed 32-bit value
  function automatic logic [DATA_W:0] mag33(input logic [DATA_W-1:0] v);
    logic [DATA_W:0] ext;
    ext = {v[DATA_W-1], v};
    return v[DATA_W-1] ? ((DATA_W+1)'(0) - ext) : ext;
  endfunction

  // saturate a signed 64-bit value to the signed 32-bit range
  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) return 32'h7FFF_FFFF;
    if (v < lo) return 32'h8000_0000;
    return v[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/m4i_if.sv =====
// m4i_if: valid/ready channel interfaces for elements, results and register writes.
// Depends on m4i_pkg for field widths.
`default_nettype none

interface m4i_elem_if;
  logic valid;
  logic ready;
  logic [m4i_pkg::DATA_W-1:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface m4i_res_if;
  logic valid;
  logic ready;
  logic [m4i_pkg::DATA_W-1:0] inverse_element;
  logic [m4i_pkg::INDEX_W-1:0] element_index;
  logic invertible;
  logic last_of_run;
  modport source (output valid, output inverse_element, output element_index,
                  output invertible, output last_of_run, input ready);
  modport sink (input valid, input inverse_element, input element_index,
                input invertible, input last_of_run, output ready);
endinterface

interface m4i_cfg_if;
  logic valid;
  logic ready;
  logic [m4i_pkg::CFG_IDX_W-1:0] index;
  logic [m4i_pkg::DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/m4i_front.sv =====
// m4i_front: accepts matrix elements, tags each with its row, column and
// end-of-matrix flag, and pushes it to the queue. Depends on m4i_pkg.
`default_nettype none

module m4i_front #(
  parameter int MATRIX_ORDER = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [m4i_pkg::DATA_W-1:0] element_value,
  output logic push_valid,
  input  wire logic push_ready,
  output logic [m4i_pkg::DATA_W+2*$clog2(MATRIX_ORDER):0] push_data
);
  import m4i_pkg::*;

  localparam int RW = $clog2(MATRIX_ORDER);

  logic [RW-1:0] row;
  logic [RW-1:0] col;
  logic last;

  assign last = (row == RW'(MATRIX_ORDER - 1)) && (col == RW'(MATRIX_ORDER - 1));
  assign in_ready = push_ready;
  assign push_valid = in_valid;
  assign push_data = {element_value, row, col, last};

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (in_valid && push_ready) begin
      if (col == RW'(MATRIX_ORDER - 1)) begin
        col <= '0;
        row <= last ? '0 : row + RW'(1);
      end else begin
        col <= col + RW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m4i_queue.sv =====
// m4i_queue: small fifo between the front and the elimination engine.
// DEPTH must be a power of two. No package dependencies.
`default_nettype none

module m4i_queue #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic pop_valid,
  input  wire logic pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CNTW-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CNTW'(1);
      else if (do_pop && !do_push) count <= count - CNTW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m4i_div.sv =====
// m4i_div: iterative restoring divider, (num * 2^FRAC_BITS) / den truncated
// toward zero and saturated to 32 bits. One quotient bit per cycle. Depends on m4i_pkg.
`default_nettype none

module m4i_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [m4i_pkg::DATA_W-1:0] num,
  input  wire logic [m4i_pkg::DATA_W-1:0] den,
  output logic done,
  output logic [m4i_pkg::DATA_W-1:0] quot
);
  import m4i_pkg::*;

  localparam int NW = DATA_W + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0] dvd;
  logic [DATA_W-1:0] dsr;
  logic [DATA_W-1:0] rem;
  logic [CNTW-1:0] cnt;
  logic busy;
  logic neg;
  logic [DATA_W:0] trial;
  logic fits;
  logic [DATA_W-1:0] num_mag;
  logic [DATA_W-1:0] den_mag;

  assign num_mag = num[DATA_W-1] ? (DATA_W'(0) - num) : num;
  assign den_mag = den[DATA_W-1] ? (DATA_W'(0) - den) : den;
  assign trial = {rem, dvd[NW-1]};
  assign fits = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {num_mag, FRAC_BITS'(0)};
      dsr <= den_mag;
      rem <= '0;
      neg <= num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy) begin
      rem <= fits ? DATA_W'(trial - {1'b0, dsr}) : trial[DATA_W-1:0];
      dvd <= {dvd[NW-2:0], fits};
    end
  end

  // sign and saturation of the finished quotient
  always_comb begin
    if (neg) begin
      if (dvd > NW'(33'h0_8000_0000)) quot = 32'h8000_0000;
      else quot = DATA_W'(0) - dvd[DATA_W-1:0];
    end else begin
      if (dvd > NW'(32'h7FFF_FFFF)) quot = 32'h7FFF_FFFF;
      else quot = dvd[DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m4i_engine.sv =====
// m4i_engine: augmented store, elimination sequencer and result register.
// Depends on m4i_pkg and m4i_div.
`default_nettype none

module m4i_engine #(
  parameter int MATRIX_ORDER = 4,
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire logic [m4i_pkg::DATA_W+2*$clog2(MATRIX_ORDER):0] q_data,
  input  wire logic [m4i_pkg::EPS_W-1:0] pivot_epsilon,
  input  wire logic [m4i_pkg::EPS_W-1:0] factor_epsilon,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [m4i_pkg::DATA_W-1:0] inverse_element,
  output logic [m4i_pkg::INDEX_W-1:0] element_index,
  output logic invertible,
  output logic last_of_run
);
  import m4i_pkg::*;

  localparam int N = MATRIX_ORDER;
  localparam int RW = $clog2(N);
  localparam int CW = $clog2(2 * N);
  localparam int AW = RW + CW;
  localparam int KW = $clog2(N * N);
  localparam int QW = DATA_W + 2 * RW + 1;
  localparam logic signed [63:0] BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] rv,
                                              input logic [CW-1:0] cv);
    return {rv, cv};
  endfunction

  logic [DATA_W-1:0] store [2**AW];
  logic [DATA_W-1:0] rdata;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  eng_state_t state, state_next;
  logic [RW-1:0] p, p_next;
  logic [RW-1:0] r, r_next;
  logic [RW-1:0] best, best_next;
  logic [CW-1:0] c, c_next;
  logic [KW-1:0] k, k_next;
  logic [DATA_W:0] bestmag, bestmag_next;
  logic [DATA_W-1:0] piv, piv_next;
  logic [DATA_W-1:0] tmp, tmp_next;
  logic [DATA_W-1:0] f, f_next;
  logic signed [63:0] prod, prod_next;
  logic signed [63:0] quo, quo_next;
  logic out_valid_next;
  logic [DATA_W-1:0] inverse_element_next;
  logic [INDEX_W-1:0] element_index_next;
  logic invertible_next;
  logic last_of_run_next;

  logic div_start;
  logic div_done;
  logic [DATA_W-1:0] div_quot;

  logic [DATA_W-1:0] q_value;
  logic [RW-1:0] q_row;
  logic [RW-1:0] q_col;
  logic q_last;
  logic [CW-1:0] c_last;
  logic [CW-1:0] c_half_last;
  logic [CW-1:0] right_col;
  logic [DATA_W:0] cur_mag;
  logic out_free;
  logic signed [63:0] diff;

  assign {q_value, q_row, q_col, q_last} = q_data[QW-1:0];
  assign c_last = CW'(2 * N - 1);
  assign c_half_last = CW'(N - 1);
  assign right_col = CW'(N) + c;
  assign cur_mag = mag33(rdata);
  assign out_free = !out_valid || out_ready;
  assign diff = {{32{rdata[DATA_W-1]}}, rdata} - quo;

  m4i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rdata),
    .den   (piv),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    rdata <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      out_valid <= 1'b0;
      p <= '0;
      r <= '0;
      c <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      p <= p_next;
      r <= r_next;
      c <= c_next;
      k <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    best <= best_next;
    bestmag <= bestmag_next;
    piv <= piv_next;
    tmp <= tmp_next;
    f <= f_next;
    prod <= prod_next;
    quo <= quo_next;
    inverse_element <= inverse_element_next;
    element_index <= element_index_next;
    invertible <= invertible_next;
    last_of_run <= last_of_run_next;
  end

  always_comb begin
    state_next = state;
    p_next = p;
    r_next = r;
    c_next = c;
    k_next = k;
    best_next = best;
    bestmag_next = bestmag;
    piv_next = piv;
    tmp_next = tmp;
    f_next = f;
    prod_next = prod;
    quo_next = quo;
    out_valid_next = out_valid && !out_ready;
    inverse_element_next = inverse_element;
    element_index_next = element_index;
    invertible_next = invertible;
    last_of_run_next = last_of_run;
    q_ready = 1'b0;
    div_start = 1'b0;
    rd_addr = cell_addr(r, c);
    wr_en = 1'b0;
    wr_addr = cell_addr(r, c);
    wr_data = rdata;

    unique case (state)
      ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          wr_en = 1'b1;
          wr_addr = cell_addr(q_row, CW'(q_col));
          wr_data = q_value;
          if (q_last) begin
            r_next = '0;
            c_next = '0;
            state_next = ST_INIT;
          end
        end
      end
      // identity into the right half
      ST_INIT: begin
        wr_en = 1'b1;
        wr_addr = cell_addr(r, right_col);
        wr_data = (CW'(r) == c) ? DATA_W'(64'd1 << FRAC_BITS) : '0;
        if (c == c_half_last) begin
          c_next = '0;
          if (r == RW'(N - 1)) begin
            p_next = '0;
            r_next = '0;
            state_next = ST_SRCH_RD;
          end else begin
            r_next = r + RW'(1);
          end
        end else begin
          c_next = c + CW'(1);
        end
      end
      ST_SRCH_RD: begin
        rd_addr = cell_addr(r, CW'(p));
        state_next = ST_SRCH_CHK;
      end
      // earlier row wins on a tie
      ST_SRCH_CHK: begin
        if (r == p || cur_mag > bestmag) begin
          bestmag_next = cur_mag;
          best_next = r;
        end
        if (r == RW'(N - 1)) begin
          state_next = ST_PIV_TEST;
        end else begin
          r_next = r + RW'(1);
          state_next = ST_SRCH_RD;
        end
      end
      ST_PIV_TEST: begin
        c_next = '0;
        if (bestmag <= (DATA_W+1)'(pivot_epsilon)) begin
          state_next = ST_OUT_SING;
        end else if (best != p) begin
          state_next = ST_SWP_RDA;
        end else begin
          state_next = ST_PIV_RD;
        end
      end
      ST_SWP_RDA: begin
        rd_addr = cell_addr(p, c);
        state_next = ST_SWP_RDB;
      end
      ST_SWP_RDB: begin
        tmp_next = rdata;
        rd_addr = cell_addr(best, c);
        state_next = ST_SWP_WRA;
      end
      ST_SWP_WRA: begin
        wr_en = 1'b1;
        wr_addr = cell_addr(p, c);
        wr_data = rdata;
        state_next = ST_SWP_WRB;
      end
      ST_SWP_WRB: begin
        wr_en = 1'b1;
        wr_addr = cell_addr(best, c);
        wr_data = tmp;
        if (c == c_last) begin
          c_next = '0;
          state_next = ST_PIV_RD;
        end else begin
          c_next = c + CW'(1);
          state_next = ST_SWP_RDA;
        end
      end
      ST_PIV_RD: begin
        rd_addr = cell_addr(p, CW'(p));
        state_next = ST_PIV_LAT;
      end
      ST_PIV_LAT: begin
        piv_next = rdata;
        c_next = '0;
        state_next = ST_DIV_RD;
      end
      ST_DIV_RD: begin
        rd_addr = cell_addr(p, c);
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          wr_en = 1'b1;
          wr_addr = cell_addr(p, c);
          wr_data = div_quot;
          if (c == c_last) begin
            r_next = '0;
            state_next = ST_FAC_RD;
          end else begin
            c_next = c + CW'(1);
            state_next = ST_DIV_RD;
          end
        end
      end
      ST_FAC_RD: begin
        rd_addr = cell_addr(r, CW'(p));
        state_next = (r == p) ? ST_ROW_NEXT : ST_FAC_CHK;
      end
      ST_FAC_CHK: begin
        f_next = rdata;
        c_next = '0;
        if (cur_mag <= (DATA_W+1)'(factor_epsilon)) state_next = ST_ROW_NEXT;
        else state_next = ST_MUL_RDP;
      end
      ST_MUL_RDP: begin
        rd_addr = cell_addr(p, c);
        state_next = ST_MUL_PROD;
      end
      ST_MUL_PROD: begin
        prod_next = $signed(f) * $signed(rdata);
        state_next = ST_MUL_TRN;
      end
      // scale down, rounding toward zero
      ST_MUL_TRN: begin
        quo_next = (prod + (prod[63] ? BIAS : 64'sd0)) >>> FRAC_BITS;
        rd_addr = cell_addr(r, c);
        state_next = ST_MUL_SUB;
      end
      ST_MUL_SUB: begin
        wr_en = 1'b1;
        wr_addr = cell_addr(r, c);
        wr_data = sat32(diff);
        if (c == c_last) begin
          state_next = ST_ROW_NEXT;
        end else begin
          c_next = c + CW'(1);
          state_next = ST_MUL_RDP;
        end
      end
      ST_ROW_NEXT: begin
        if (r == RW'(N - 1)) begin
          if (p == RW'(N - 1)) begin
            r_next = '0;
            c_next = '0;
            k_next = '0;
            state_next = ST_OUT_RD;
          end else begin
            p_next = p + RW'(1);
            r_next = p + RW'(1);
            state_next = ST_SRCH_RD;
          end
        end else begin
          r_next = r + RW'(1);
          state_next = ST_FAC_RD;
        end
      end
      ST_OUT_RD: begin
        rd_addr = cell_addr(r, right_col);
        state_next = ST_OUT_PUT;
      end
      ST_OUT_PUT: begin
        rd_addr = cell_addr(r, right_col);
        if (out_free) begin
          out_valid_next = 1'b1;
          inverse_element_next = rdata;
          element_index_next = INDEX_W'(k);
          invertible_next = 1'b1;
          last_of_run_next = (k == KW'(N * N - 1));
          if (k == KW'(N * N - 1)) begin
            state_next = ST_LOAD;
          end else begin
            k_next = k + KW'(1);
            state_next = ST_OUT_RD;
            if (c == c_half_last) begin
              c_next = '0;
              r_next = r + RW'(1);
            end else begin
              c_next = c + CW'(1);
            end
          end
        end
      end
      ST_OUT_SING: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          inverse_element_next = '0;
          element_index_next = '0;
          invertible_next = 1'b0;
          last_of_run_next = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/matrix4_inverse_gauss_jordan.sv =====
// matrix4_inverse_gauss_jordan: top level; front, queue and elimination engine
// plus the two epsilon registers. Depends on m4i_pkg, m4i_if, m4i_front, m4i_queue and m4i_engine.
//
//  channel  | modport | moves per transaction
//  ---------+---------+------------------------------------------------------
//  element  | sink    | element_value, one matrix element, row-major
//  result   | source  | inverse_element, element_index, invertible, last_of_run
//  cfg      | sink    | index, data: write of pivot_epsilon (0) or factor_epsilon (1)
//
// Elements are taken one per cycle into a queue while it has room; the engine
// then runs the elimination on one matrix at a time. Per pivot it divides the
// pivot row in the shared bit-serial divider, then runs the multiply-subtract
// sweep over the other rows; at Q16.16 a 4x4 matrix's time is set mostly by
// the divider. Results leave through an output register; a stalled result holds
// the engine but not the element queue, which takes elements until it is full.
// rst is synchronous; there is no clearing pass.
`default_nettype none

module matrix4_inverse_gauss_jordan #(
  parameter int MATRIX_ORDER = 4,
  parameter int FRAC_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  m4i_elem_if.sink element,
  m4i_res_if.source result,
  m4i_cfg_if.sink cfg
);
  import m4i_pkg::*;

  localparam int RW = $clog2(MATRIX_ORDER);
  localparam int QW = DATA_W + 2 * RW + 1;
  localparam int QDEPTH = 2;

  logic [EPS_W-1:0] pivot_epsilon;
  logic [EPS_W-1:0] factor_epsilon;

  logic push_valid;
  logic push_ready;
  logic [QW-1:0] push_data;
  logic pop_valid;
  logic pop_ready;
  logic [QW-1:0] pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_epsilon <= EPS_W'(1);
      factor_epsilon <= EPS_W'(1);
    end else if (cfg.valid) begin
      if (cfg.index == CFG_PIVOT_EPS) pivot_epsilon <= cfg.data[EPS_W-1:0];
      if (cfg.index == CFG_FACTOR_EPS) factor_epsilon <= cfg.data[EPS_W-1:0];
    end
  end

  m4i_front #(.MATRIX_ORDER(MATRIX_ORDER)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (element.valid),
    .in_ready      (element.ready),
    .element_value (element.element_value),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  m4i_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  m4i_engine #(.MATRIX_ORDER(MATRIX_ORDER), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (pop_valid),
    .q_ready         (pop_ready),
    .q_data          (pop_data),
    .pivot_epsilon   (pivot_epsilon),
    .factor_epsilon  (factor_epsilon),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .inverse_element (result.inverse_element),
    .element_index   (result.element_index),
    .invertible      (result.invertible),
    .last_of_run     (result.last_of_run)
  );

endmodule

`default_nettype wire

// ===== rtl/m4i_checker.sv =====
// m4i_checker: port-level assertions on the result channel, bound to the top level.
// Depends on m4i_pkg for widths.
`default_nettype none

module m4i_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [m4i_pkg::DATA_W-1:0] inverse_element,
  input wire logic [m4i_pkg::INDEX_W-1:0] element_index,
  input wire logic invertible,
  input wire logic last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && !invertible |-> last_of_run && inverse_element == '0 &&
                                 element_index == '0)
    else $error("singular result malformed");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=>
      !out_valid || (invertible && element_index == 4'($past(element_index) + 4'd1)))
    else $error("result index out of order");

endmodule

bind matrix4_inverse_gauss_jordan m4i_checker u_m4i_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .inverse_element (result.inverse_element),
  .element_index   (result.element_index),
  .invertible      (result.invertible),
  .last_of_run     (result.last_of_run)
);

`default_nettype wire
